>>> rtl/mlst_pkg.sv
// mlst_pkg: types, constants and angle helpers for the mount laying slew tracker
// no dependencies; imported by every module of the block

package mlst_pkg;

    localparam int FULL_TURN = 23040;
    localparam int HALF_TURN = 11520;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int STEP_W      = 14;

    localparam logic [CFG_INDEX_W-1:0] CFG_MOUNT_HEADING     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAVERSE_HALF_ARC = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEVATION_MIN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEVATION_MAX     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAVERSE_RATE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEVATION_RATE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_TARGET_TOL     = 3'd6;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    typedef logic [14:0]        azim_t;
    typedef logic signed [13:0] elev_t;
    typedef logic signed [14:0] adelta_t;
    typedef logic [13:0]        step_t;

    localparam azim_t       RST_HEADING  = 15'd0;
    localparam logic [13:0] RST_HALF_ARC = 14'd11520;
    localparam elev_t       RST_EL_MIN   = -14'sd320;
    localparam elev_t       RST_EL_MAX   = 14'sd4480;
    localparam logic [14:0] RST_AZ_RATE  = 15'd640;
    localparam step_t       RST_EL_RATE  = 14'd320;
    localparam logic [13:0] RST_TOL      = 14'd16;

    localparam step_t STEP_MAX = {STEP_W{1'b1}};

    typedef struct packed {
        azim_t       heading;
        logic [13:0] half_arc;
        elev_t       el_min;
        elev_t       el_max;
        logic [14:0] az_rate;
        step_t       el_rate;
        logic [13:0] tol;
    } cfg_t;

    typedef struct packed {
        logic  func;
        azim_t want_az;
        elev_t want_el;
        step_t step_az;
        step_t step_el;
    } item_t;

    typedef struct packed {
        azim_t az_now;
        elev_t el_now;
        azim_t az_goal;
        elev_t el_goal;
        logic  in_arc;
    } track_t;

    function automatic azim_t wrap_raw(input azim_t a);
        return (a >= 15'(FULL_TURN)) ? azim_t'(a - 15'(FULL_TURN)) : a;
    endfunction

    // shortest way round, exactly half a turn gives minus half a turn
    function automatic adelta_t short_delta(input azim_t from, input azim_t to);
        logic signed [15:0] d;
        d = $signed({1'b0, to}) - $signed({1'b0, from});
        if (d >= 16'sd11520) begin
            return adelta_t'(d - 16'sd23040);
        end else if (d < -16'sd11520) begin
            return adelta_t'(d + 16'sd23040);
        end
        return adelta_t'(d);
    endfunction

    function automatic azim_t wrap_add(input azim_t base, input adelta_t off);
        logic signed [16:0] s;
        s = $signed({2'b00, base}) + 17'(off);
        if (s < 17'sd0) begin
            s = s + 17'sd23040;
        end else if (s >= 17'sd23040) begin
            s = s - 17'sd23040;
        end
        return s[14:0];
    endfunction

    function automatic logic [14:0] abs_delta(input adelta_t d);
        return (d < 0) ? 15'(-d) : 15'(d);
    endfunction

endpackage

>>> rtl/mlst_in_stage.sv
// mlst_in_stage: input register of the tracker, with the slew step multiplies
// depends on mlst_pkg

module mlst_in_stage #(
    parameter int TIME_FRACTION_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 func,
    input  mlst_pkg::azim_t      desired_azimuth,
    input  mlst_pkg::elev_t      desired_elevation,
    input  logic [15:0]          elapsed_time,
    input  mlst_pkg::cfg_t       cfg,
    input  logic                 advance,
    output logic                 item_valid,
    output mlst_pkg::item_t      item
);
    import mlst_pkg::*;

    localparam int AZ_PROD_W = 31;
    localparam int EL_PROD_W = 30;

    logic                 valid_reg, valid_next;
    item_t                item_reg, item_next;
    logic [AZ_PROD_W-1:0] az_prod, az_shift;
    logic [EL_PROD_W-1:0] el_prod, el_shift;
    logic                 load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        az_prod  = AZ_PROD_W'(cfg.az_rate) * AZ_PROD_W'(elapsed_time);
        el_prod  = EL_PROD_W'(cfg.el_rate) * EL_PROD_W'(elapsed_time);
        az_shift = az_prod >> TIME_FRACTION_BITS;
        el_shift = el_prod >> TIME_FRACTION_BITS;

        item_next.func    = func;
        item_next.want_az = desired_azimuth;
        item_next.want_el = desired_elevation;
        // steps beyond any reachable error saturate
        item_next.step_az = (az_shift > AZ_PROD_W'(STEP_MAX)) ? STEP_MAX
                                                              : az_shift[STEP_W-1:0];
        item_next.step_el = (el_shift > EL_PROD_W'(STEP_MAX)) ? STEP_MAX
                                                              : el_shift[STEP_W-1:0];

        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/mlst_track_core.sv
// mlst_track_core: angle and target state with the order and tick update logic
// depends on mlst_pkg

module mlst_track_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  mlst_pkg::item_t  item,
    input  mlst_pkg::cfg_t   cfg,
    input  logic             update,
    output mlst_pkg::track_t result
);
    import mlst_pkg::*;

    azim_t az_cur_reg, az_cur_next;
    azim_t az_tgt_reg, az_tgt_next;
    elev_t el_cur_reg, el_cur_next;
    elev_t el_tgt_reg, el_tgt_next;

    azim_t              want_az, heading;
    adelta_t            off, half_s, daz, step_az_s;
    logic [14:0]        off_mag, daz_mag, del_mag;
    logic signed [14:0] del, el_sum;
    logic               in_arc;

    always_comb begin
        want_az   = wrap_raw(item.want_az);
        heading   = wrap_raw(cfg.heading);
        half_s    = $signed({1'b0, cfg.half_arc});
        off       = short_delta(heading, want_az);
        off_mag   = abs_delta(off);
        daz       = short_delta(az_cur_reg, az_tgt_reg);
        daz_mag   = abs_delta(daz);
        step_az_s = $signed({1'b0, item.step_az});
        del       = 15'(el_tgt_reg) - 15'(el_cur_reg);
        del_mag   = (del < 0) ? 15'(-del) : 15'(del);
        el_sum    = (del < 0) ? 15'(el_cur_reg) - $signed({1'b0, item.step_el})
                              : 15'(el_cur_reg) + $signed({1'b0, item.step_el});

        az_cur_next = az_cur_reg;
        az_tgt_next = az_tgt_reg;
        el_cur_next = el_cur_reg;
        el_tgt_next = el_tgt_reg;
        in_arc      = 1'b1;

        if (!item.func) begin
            if (cfg.half_arc >= 14'(HALF_TURN)) begin
                az_tgt_next = want_az;
            end else begin
                in_arc = off_mag <= {1'b0, cfg.half_arc};
                priority if (off < -half_s) begin
                    az_tgt_next = wrap_add(heading, -half_s);
                end else if (off > half_s) begin
                    az_tgt_next = wrap_add(heading, half_s);
                end else begin
                    az_tgt_next = wrap_add(heading, off);
                end
            end
            priority if (item.want_el < cfg.el_min) begin
                el_tgt_next = cfg.el_min;
            end else if (item.want_el < cfg.el_max) begin
                el_tgt_next = item.want_el;
            end else begin
                el_tgt_next = cfg.el_max;
            end
        end else begin
            if (daz_mag <= {1'b0, item.step_az}) begin
                az_cur_next = az_tgt_reg;
            end else begin
                az_cur_next = wrap_add(az_cur_reg, (daz < 0) ? -step_az_s : step_az_s);
            end
            if (del_mag <= {1'b0, item.step_el}) begin
                el_cur_next = el_tgt_reg;
            end else begin
                el_cur_next = el_sum[13:0];
            end
        end

        result.az_now  = az_cur_next;
        result.el_now  = el_cur_next;
        result.az_goal = az_tgt_next;
        result.el_goal = el_tgt_next;
        result.in_arc  = in_arc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_cur_reg <= '0;
            az_tgt_reg <= '0;
            el_cur_reg <= '0;
            el_tgt_reg <= '0;
        end else if (update) begin
            az_cur_reg <= az_cur_next;
            az_tgt_reg <= az_tgt_next;
            el_cur_reg <= el_cur_next;
            el_tgt_reg <= el_tgt_next;
        end
    end

endmodule

>>> rtl/mlst_out_stage.sv
// mlst_out_stage: result register, on-target check and master stream side
// depends on mlst_pkg

module mlst_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  mlst_pkg::track_t                 result,
    input  logic [13:0]                      tol,
    output logic                             advance,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // az_now, el_now, az_goal, el_goal, on_target, request_in_arc, zero pad
    output logic [mlst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mlst_pkg::*;

    logic               valid_reg, valid_next;
    track_t             res_reg;
    logic [14:0]        eaz;
    logic signed [14:0] del;
    logic [14:0]        eel;
    logic               on_target;

    assign advance = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = advance ? in_valid : valid_reg;
        eaz        = abs_delta(short_delta(res_reg.az_now, res_reg.az_goal));
        del        = 15'(res_reg.el_goal) - 15'(res_reg.el_now);
        eel        = (del < 0) ? 15'(-del) : 15'(del);
        on_target  = (eaz <= {1'b0, tol}) && (eel <= {1'b0, tol});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0000, res_reg.in_arc, on_target, res_reg.el_goal,
                            res_reg.az_goal, res_reg.el_now, res_reg.az_now};

endmodule

>>> rtl/mount_laying_slew_tracker.sv
// mount_laying_slew_tracker: two-axis mount tracker top level, config registers
// depends on mlst_pkg, mlst_in_stage, mlst_track_core, mlst_out_stage
//
//  channel   ports          moves
//  input     s_axis_*       order (tuser 0) or tick (tuser 1)
//  result    m_axis_*       angles, goals and flags, one per input transaction
//  config    cfg_*          register write, no read-back
//
// one transaction a cycle while the result is not stalled; input register, then result register
// step multiplies sit before the input register, state update before the result
// aresetn clears state to zero and config to its defaults
// a stalled result holds the pipe; the input side stays open while one slot is free

module mount_laying_slew_tracker #(
    parameter int TIME_FRACTION_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // desired_azimuth, desired_elevation, elapsed_time, zero pad
    input  logic [mlst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // azimuth_now, elevation_now, azimuth_goal, elevation_goal, on_target, request_in_arc
    output logic [mlst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [mlst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mlst_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    item_t  item;
    track_t result;
    logic   item_valid;
    logic   advance;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MOUNT_HEADING:     cfg_next.heading  = cfg_wdata;
                CFG_TRAVERSE_HALF_ARC: cfg_next.half_arc = cfg_wdata[13:0];
                CFG_ELEVATION_MIN:     cfg_next.el_min   = cfg_wdata[13:0];
                CFG_ELEVATION_MAX:     cfg_next.el_max   = cfg_wdata[13:0];
                CFG_TRAVERSE_RATE:     cfg_next.az_rate  = cfg_wdata;
                CFG_ELEVATION_RATE:    cfg_next.el_rate  = cfg_wdata[13:0];
                CFG_ON_TARGET_TOL:     cfg_next.tol      = cfg_wdata[13:0];
                default:               cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heading  <= RST_HEADING;
            cfg_reg.half_arc <= RST_HALF_ARC;
            cfg_reg.el_min   <= RST_EL_MIN;
            cfg_reg.el_max   <= RST_EL_MAX;
            cfg_reg.az_rate  <= RST_AZ_RATE;
            cfg_reg.el_rate  <= RST_EL_RATE;
            cfg_reg.tol      <= RST_TOL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mlst_in_stage #(
        .TIME_FRACTION_BITS(TIME_FRACTION_BITS)
    ) u_in_stage (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_axis_tvalid),
        .s_ready           (s_axis_tready),
        .func              (s_axis_tuser),
        .desired_azimuth   (s_axis_tdata[14:0]),
        .desired_elevation (s_axis_tdata[28:15]),
        .elapsed_time      (s_axis_tdata[44:29]),
        .cfg               (cfg_reg),
        .advance           (advance),
        .item_valid        (item_valid),
        .item              (item)
    );

    mlst_track_core u_track_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .cfg     (cfg_reg),
        .update  (item_valid && advance),
        .result  (result)
    );

    mlst_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (item_valid),
        .result        (result),
        .tol           (cfg_reg.tol),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are stalled");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> item_valid)
        else $error("accepted transaction lost from the input register");

    a_azimuth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[14:0] < 15'(FULL_TURN))
                          && (m_axis_tdata[43:29] < 15'(FULL_TURN)))
        else $error("azimuth result beyond a full turn");

endmodule

>>> sim/testbench.sv
// testbench for mount_laying_slew_tracker: scoreboard class predicting angles, goals and flags
// directed and random orders and ticks over several register settings; depends on mlst_pkg

import mlst_pkg::*;

localparam int TIME_FRACTION_BITS = 10;

typedef enum logic {
    FUNC_ORDER = 1'b0,
    FUNC_TICK  = 1'b1
} func_e;

typedef struct {
    int az_now;
    int el_now;
    int az_goal;
    int el_goal;
    int on_target;
    int in_arc;
} laying_result_t;

class laying_scoreboard;
    int heading, half_arc, el_min, el_max, az_rate, el_rate, tol;
    int az_cur, az_tgt, el_cur, el_tgt;
    int fails;
    laying_result_t laying_q[$];

    function new();
        heading  = 0;
        half_arc = 11520;
        el_min   = -320;
        el_max   = 4480;
        az_rate  = 640;
        el_rate  = 320;
        tol      = 16;
        az_cur   = 0;
        az_tgt   = 0;
        el_cur   = 0;
        el_tgt   = 0;
        fails    = 0;
    endfunction

    function int wrap_turn(longint a);
        longint r;
        r = a % FULL_TURN;
        if (r < 0) begin
            r += FULL_TURN;
        end
        return int'(r);
    endfunction

    function int shortest(int from, int to);
        int d;
        d = wrap_turn(longint'(to) - longint'(from));
        if (d >= HALF_TURN) begin
            d -= FULL_TURN;
        end
        return d;
    endfunction

    function longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_MOUNT_HEADING:     heading  = int'(v);
            CFG_TRAVERSE_HALF_ARC: half_arc = int'(v[13:0]);
            CFG_ELEVATION_MIN:     el_min   = int'($signed(v[13:0]));
            CFG_ELEVATION_MAX:     el_max   = int'($signed(v[13:0]));
            CFG_TRAVERSE_RATE:     az_rate  = int'(v);
            CFG_ELEVATION_RATE:    el_rate  = int'(v[13:0]);
            CFG_ON_TARGET_TOL:     tol      = int'(v[13:0]);
            default: ;
        endcase
    endfunction

    // work out the laying after one transaction and queue it
    function void predict_laying(func_e func, int az_in, int el_in, int et);
        int want_az, hd, off;
        longint saz, sel, daz, del, eaz, eel;
        laying_result_t r;
        want_az  = wrap_turn(az_in);
        r.in_arc = 1;
        if (func == FUNC_ORDER) begin
            if (half_arc >= HALF_TURN) begin
                az_tgt = want_az;
            end else begin
                hd  = wrap_turn(heading);
                off = shortest(hd, want_az);
                r.in_arc = (mag(off) <= half_arc) ? 1 : 0;
                if (off < -half_arc) begin
                    off = -half_arc;
                end
                if (off > half_arc) begin
                    off = half_arc;
                end
                az_tgt = wrap_turn(longint'(hd) + off);
            end
            if (el_in < el_min) begin
                el_tgt = el_min;
            end else if (el_in < el_max) begin
                el_tgt = el_in;
            end else begin
                el_tgt = el_max;
            end
        end else if (et != 0) begin
            saz = (longint'(az_rate) * longint'(et)) >>> TIME_FRACTION_BITS;
            sel = (longint'(el_rate) * longint'(et)) >>> TIME_FRACTION_BITS;
            daz = shortest(az_cur, az_tgt);
            del = longint'(el_tgt) - longint'(el_cur);
            if (mag(daz) <= saz) begin
                az_cur = az_tgt;
            end else begin
                az_cur = wrap_turn(longint'(az_cur) + ((daz < 0) ? -saz : saz));
            end
            if (mag(del) <= sel) begin
                el_cur = el_tgt;
            end else begin
                el_cur = int'(longint'(el_cur) + ((del < 0) ? -sel : sel));
            end
        end
        eaz = mag(shortest(az_cur, az_tgt));
        eel = mag(longint'(el_tgt) - longint'(el_cur));
        r.az_now    = az_cur;
        r.el_now    = el_cur;
        r.az_goal   = az_tgt;
        r.el_goal   = el_tgt;
        r.on_target = (eaz <= tol && eel <= tol) ? 1 : 0;
        laying_q.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
        end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td);
        laying_result_t e;
        if (laying_q.size() == 0) begin
            $error("result transaction with nothing expected");
            fails++;
            return;
        end
        e = laying_q.pop_front();
        compare_field("azimuth_now", e.az_now, int'(td[14:0]));
        compare_field("elevation_now", e.el_now, int'($signed(td[28:15])));
        compare_field("azimuth_goal", e.az_goal, int'(td[43:29]));
        compare_field("elevation_goal", e.el_goal, int'($signed(td[57:44])));
        compare_field("on_target", e.on_target, int'(td[58]));
        compare_field("request_in_arc", e.in_arc, int'(td[59]));
    endfunction

    function int pending();
        return laying_q.size();
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 100;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    laying_scoreboard sb;
    bit idle_on;
    bit hold_req;
    int hold_cnt;
    int cycles;

    mount_laying_slew_tracker #(
        .TIME_FRACTION_BITS(TIME_FRACTION_BITS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check accepted transactions, random backpressure, long hold on request
    initial begin
        m_axis_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < 36);
            end
        end
    end

    task automatic send_item(input func_e func, input logic [14:0] az,
                             input logic signed [13:0] el, input logic [15:0] et);
        while (idle_on && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {3'b000, et, el, az};
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        sb.predict_laying(func, int'(az), int'(el), int'(et));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input int heading, input int half, input int el_lo,
                                 input int el_hi, input int az_r, input int el_r,
                                 input int tol);
        logic [CFG_INDEX_W-1:0] idx [7];
        logic [CFG_DATA_W-1:0]  val [7];
        idx[0] = CFG_MOUNT_HEADING;     val[0] = 15'(heading);
        idx[1] = CFG_TRAVERSE_HALF_ARC; val[1] = 15'(half);
        idx[2] = CFG_ELEVATION_MIN;     val[2] = 15'(el_lo);
        idx[3] = CFG_ELEVATION_MAX;     val[3] = 15'(el_hi);
        idx[4] = CFG_TRAVERSE_RATE;     val[4] = 15'(az_r);
        idx[5] = CFG_ELEVATION_RATE;    val[5] = 15'(el_r);
        idx[6] = CFG_ON_TARGET_TOL;     val[6] = 15'(tol);
        wait_idle();
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_setting();
        int heading, half, lo, hi, tmp, az_r, el_r, tol;
        heading = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(23039);
        half    = ($urandom_range(3) == 0) ? $urandom_range(16383, 11520)
                                           : $urandom_range(11519);
        lo      = int'($urandom_range(11520)) - 5760;
        hi      = int'($urandom_range(11520)) - 5760;
        if (lo > hi && $urandom_range(3) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        az_r    = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(2000);
        el_r    = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(1000);
        tol     = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(64);
        write_setting(heading, half, lo, hi, az_r, el_r, tol);
    endtask

    // random mix of orders and mostly ticks so the mount actually slews between goals
    task automatic run_phase(input int n);
        func_e func;
        logic [14:0] az;
        logic signed [13:0] el;
        logic [15:0] et;
        for (int i = 0; i < n; i++) begin
            func = ($urandom_range(99) < 30) ? FUNC_ORDER : FUNC_TICK;
            az   = ($urandom_range(7) == 0) ? 15'($urandom) : 15'($urandom_range(23039));
            el   = ($urandom_range(7) == 0) ? 14'($urandom)
                                            : 14'(int'($urandom_range(11520)) - 5760);
            case ($urandom_range(9))
                0:       et = 16'($urandom);
                1:       et = 16'd0;
                default: et = 16'($urandom_range(2047));
            endcase
            send_item(func, az, el, et);
        end
    endtask

    initial begin
        sb            = new();
        idle_on       = 1;
        hold_req      = 0;
        cycles        = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = FUNC_ORDER;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_MOUNT_HEADING;
        cfg_wdata     = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: zero tick, clamps, out of range azimuth, longest tick
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'd0);
        send_item(FUNC_ORDER, 15'd0, 14'sd0, 16'd0);
        send_item(FUNC_ORDER, 15'd23039, 14'sd8191, 16'd0);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'hffff);
        send_item(FUNC_ORDER, 15'd32767, -14'sd8192, 16'hffff);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'd1);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'd1024);
        send_item(FUNC_ORDER, 15'd11520, 14'sd4479, 16'd0);
        send_item(FUNC_TICK, 15'h7fff, -14'sd1, 16'hffff);

        // narrow arc: half turn away, arc edges either side, zero tolerance
        write_setting(0, 100, -5760, 5760, 23040, 11520, 0);
        send_item(FUNC_ORDER, 15'd11520, -14'sd5760, 16'd0);
        send_item(FUNC_ORDER, 15'd100, 14'sd5760, 16'd0);
        send_item(FUNC_ORDER, 15'd101, 14'sd0, 16'd0);
        send_item(FUNC_ORDER, 15'd22940, 14'sd0, 16'd0);
        send_item(FUNC_ORDER, 15'd22939, 14'sd100, 16'd0);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'hffff);

        // zero arc, inverted elevation limits, zero rates, widest tolerance
        write_setting(32767, 0, 1000, -1000, 0, 0, 16383);
        send_item(FUNC_ORDER, 15'd9727, 14'sd0, 16'd0);
        send_item(FUNC_ORDER, 15'd0, 14'sd2000, 16'd0);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'hffff);

        // wider than unrestricted arc, full limits, top rates
        write_setting(23039, 16383, -8192, 8191, 32767, 16383, 0);
        send_item(FUNC_ORDER, 15'd11519, 14'sd8191, 16'd0);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'd3);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'hffff);
        send_item(FUNC_ORDER, 15'd0, -14'sd8192, 16'd0);
        send_item(FUNC_TICK, 15'd0, 14'sd0, 16'hffff);

        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                write_setting(0, 11520, -320, 4480, 640, 320, 16);
            end else begin
                random_setting();
            end
            idle_on = (p != 2);
            if (p == 4) begin
                hold_req = 1;
            end
            run_phase(PHASE_ITEMS);
        end
        idle_on = 1;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
